@@ src/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Schlick Fresnel package
// Item types, fixed-point constants and pipeline depth shared by the top level and checkers.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAC_BITS_DEF = 14;

   // unsigned Q.30 working format
   localparam int Q30W = 31;
   localparam logic [Q30W-1:0] ONE_Q30 = 31'h4000_0000;

   // quotient / root bits produced by the iterative units
   localparam int QUO_W = Q30W;

   // input regs, iterative units and the tail stages
   localparam int LATENCY = 5 + QUO_W + 1 + QUO_W + 6;

   typedef struct packed {
      logic signed [15:0] eye_x;
      logic signed [15:0] eye_y;
      logic signed [15:0] eye_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [15:0]        index_from;
      logic [15:0]        index_to;
   } req_type;

   typedef struct packed {
      logic [15:0] reflectance;
      logic        total_internal;
   } rsp_type;

endpackage

@@ src/sfr_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, MSB first; side data travels with each item.
// ----------------------------------------------------------------------------
module sfr_div #(
   parameter int NW = 63,
   parameter int DW = 32,
   parameter int QW = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_vld,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] side_out
);

   localparam int WW = DW + QW;

   logic [WW-1:0] rem_ff  [QW];
   logic [WW-1:0] rem_in  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [QW-1:0] vld_ff;

   logic [WW-1:0] rem_src  [QW];
   logic [DW-1:0] den_src  [QW];
   logic [QW-1:0] quo_src  [QW];
   logic [SW-1:0] side_src [QW];
   logic [QW-1:0] vld_src;
   logic [WW-1:0] sub      [QW];
   logic [QW-1:0] take;

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rem_src[k]  = WW'(num);
            den_src[k]  = den;
            quo_src[k]  = '0;
            side_src[k] = side_in;
            vld_src[k]  = in_vld;
         end else begin
            rem_src[k]  = rem_ff[(k == 0) ? 0 : k - 1];
            den_src[k]  = den_ff[(k == 0) ? 0 : k - 1];
            quo_src[k]  = quo_ff[(k == 0) ? 0 : k - 1];
            side_src[k] = side_ff[(k == 0) ? 0 : k - 1];
            vld_src[k]  = vld_ff[(k == 0) ? 0 : k - 1];
         end
         sub[k]    = WW'(den_src[k]) << (QW - 1 - k);
         take[k]   = (rem_src[k] >= sub[k]);
         rem_in[k] = take[k] ? (rem_src[k] - sub[k]) : rem_src[k];
         quo_in[k] = quo_src[k] | (take[k] ? (QW'(1) << (QW - 1 - k)) : '0);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_src[k];
         quo_ff[k]  <= quo_in[k];
         side_ff[k] <= side_src[k];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_src;
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign quo      = quo_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule

@@ src/sfr_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit root, one result bit per stage; side data rides along.
// ----------------------------------------------------------------------------
module sfr_sqrt #(
   parameter int VW = 61,
   parameter int RW = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [VW-1:0] val,
   input  logic [SW-1:0] side_in,
   output logic          out_vld,
   output logic [RW-1:0] root,
   output logic [SW-1:0] side_out
);

   localparam int WW = 2 * RW;

   logic [WW-1:0] rem_ff  [RW];
   logic [WW-1:0] rem_in  [RW];
   logic [WW-1:0] res_ff  [RW];
   logic [WW-1:0] res_in  [RW];
   logic [SW-1:0] side_ff [RW];
   logic [RW-1:0] vld_ff;

   logic [WW-1:0] rem_src  [RW];
   logic [WW-1:0] res_src  [RW];
   logic [SW-1:0] side_src [RW];
   logic [RW-1:0] vld_src;
   logic [WW-1:0] trial    [RW];
   logic [WW-1:0] bitv     [RW];

   always_comb begin
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            rem_src[k]  = WW'(val);
            res_src[k]  = '0;
            side_src[k] = side_in;
            vld_src[k]  = in_vld;
         end else begin
            rem_src[k]  = rem_ff[(k == 0) ? 0 : k - 1];
            res_src[k]  = res_ff[(k == 0) ? 0 : k - 1];
            side_src[k] = side_ff[(k == 0) ? 0 : k - 1];
            vld_src[k]  = vld_ff[(k == 0) ? 0 : k - 1];
         end
         bitv[k]  = WW'(1) << (2 * (RW - 1 - k));
         trial[k] = res_src[k] + bitv[k];
         if (rem_src[k] >= trial[k]) begin
            rem_in[k] = rem_src[k] - trial[k];
            res_in[k] = (res_src[k] >> 1) + bitv[k];
         end else begin
            rem_in[k] = rem_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RW; k++) begin
         rem_ff[k]  <= rem_in[k];
         res_ff[k]  <= res_in[k];
         side_ff[k] <= side_src[k];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_src;
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign root     = res_ff[RW-1][RW-1:0];
   assign side_out = side_ff[RW-1];

endmodule

@@ src/schlick_fresnel_reflectance.sv @@
// Each accepted item passes stages A to E, the dividers, stage F, the square root and stages G to L.
// Throughput: one item per clock outside reset; the two dividers and the square root are
// bit-per-stage pipelines of 31 stages each and set the depth.
// Reset (synchronous): clears every stage valid bit; busy is high only in reset.
// rsp_valid marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance
// Dot product, total internal reflection test, refraction cosine and the
// Schlick polynomial in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
module schlick_fresnel_reflectance #(
   parameter int FRAC_BITS = sfr_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sfr_pkg::req_type req_item,
   output logic             rsp_valid,
   output sfr_pkg::rsp_type rsp_item
);

   localparam int W = sfr_pkg::Q30W;
   localparam int QW = sfr_pkg::QUO_W;
   localparam logic [W-1:0] ONE = sfr_pkg::ONE_Q30;
   localparam logic [63:0] ONE2F = 64'(1) << (2 * FRAC_BITS);
   localparam int SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
   localparam int SH_L = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // stage A: products and index terms
   logic               a_vld_ff;
   logic signed [31:0] a_px_ff, a_py_ff, a_pz_ff;
   logic [31:0]        a_n1sq_ff, a_n2sq_ff;
   logic [15:0]        a_d_ff;
   logic [16:0]        a_s_ff;
   logic               a_gt_ff;

   always_ff @(posedge clock) begin
      a_px_ff   <= req_item.eye_x * req_item.normal_x;
      a_py_ff   <= req_item.eye_y * req_item.normal_y;
      a_pz_ff   <= req_item.eye_z * req_item.normal_z;
      a_n1sq_ff <= 32'(req_item.index_from) * 32'(req_item.index_from);
      a_n2sq_ff <= 32'(req_item.index_to) * 32'(req_item.index_to);
      a_gt_ff   <= req_item.index_from > req_item.index_to;
      a_d_ff    <= (req_item.index_from > req_item.index_to)
                   ? req_item.index_from - req_item.index_to
                   : req_item.index_to - req_item.index_from;
      a_s_ff    <= 17'(req_item.index_from) + 17'(req_item.index_to);
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
   end

   // stage B: dot sum, clamp to 0..1, Q.30
   logic signed [33:0] dot;
   logic [63:0]        dot_clamp;
   logic [W-1:0]       b_c_in;
   logic               b_vld_ff, b_gt_ff;
   logic [W-1:0]       b_c_ff;
   logic [31:0]        b_n1sq_ff, b_n2sq_ff;
   logic [15:0]        b_d_ff;
   logic [16:0]        b_s_ff;

   always_comb begin
      dot = 34'(a_px_ff) + 34'(a_py_ff) + 34'(a_pz_ff);
      if (dot < 0) begin
         dot_clamp = '0;
      end else if (64'(dot) > ONE2F) begin
         dot_clamp = ONE2F;
      end else begin
         dot_clamp = 64'(dot);
      end
      b_c_in = W'((dot_clamp >> SH_R) << SH_L);
   end

   always_ff @(posedge clock) begin
      b_c_ff    <= b_c_in;
      b_n1sq_ff <= a_n1sq_ff;
      b_n2sq_ff <= a_n2sq_ff;
      b_d_ff    <= a_d_ff;
      b_s_ff    <= a_s_ff;
      b_gt_ff   <= a_gt_ff;
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   // stage C: 1 - cos^2
   logic [61:0]  cc_full;
   logic         c_vld_ff, c_gt_ff;
   logic [W-1:0] c_om_ff, c_c_ff;
   logic [31:0]  c_n1sq_ff, c_n2sq_ff;
   logic [15:0]  c_d_ff;
   logic [16:0]  c_s_ff;

   assign cc_full = 62'(b_c_ff) * 62'(b_c_ff);

   always_ff @(posedge clock) begin
      c_om_ff   <= ONE - cc_full[60:30];
      c_c_ff    <= b_c_ff;
      c_n1sq_ff <= b_n1sq_ff;
      c_n2sq_ff <= b_n2sq_ff;
      c_d_ff    <= b_d_ff;
      c_s_ff    <= b_s_ff;
      c_gt_ff   <= b_gt_ff;
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   // stage D: sin2 numerator
   logic         d_vld_ff, d_gt_ff;
   logic [62:0]  d_num_ff;
   logic [31:0]  d_den_ff;
   logic [W-1:0] d_c_ff;
   logic [15:0]  d_d_ff;
   logic [16:0]  d_s_ff;

   always_ff @(posedge clock) begin
      d_num_ff <= 63'(c_n1sq_ff) * 63'(c_om_ff);
      d_den_ff <= c_n2sq_ff;
      d_c_ff   <= c_c_ff;
      d_d_ff   <= c_d_ff;
      d_s_ff   <= c_s_ff;
      d_gt_ff  <= c_gt_ff;
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   // stage E: total internal reflection test
   logic         e_vld_ff, e_gt_ff, e_tir_ff, e_den0_ff;
   logic [62:0]  e_num_ff;
   logic [31:0]  e_den_ff;
   logic [W-1:0] e_c_ff;
   logic [15:0]  e_d_ff;
   logic [16:0]  e_s_ff;

   always_ff @(posedge clock) begin
      e_tir_ff  <= d_gt_ff && (d_num_ff > {d_den_ff, 31'b0} >> 1);
      e_den0_ff <= (d_den_ff == '0);
      e_num_ff  <= d_num_ff;
      e_den_ff  <= d_den_ff;
      e_c_ff    <= d_c_ff;
      e_d_ff    <= d_d_ff;
      e_s_ff    <= d_s_ff;
      e_gt_ff   <= d_gt_ff;
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
   end

   // dividers: sin2 and the r0 ratio, same depth
   logic          dv1_vld, dv2_vld;
   logic [QW-1:0] q_sin2, q_ratio;
   logic [W+2:0]  dv1_side;
   logic          dv2_side;

   sfr_div #(.NW(63), .DW(32), .QW(QW), .SW(W + 3)) u_div_sin2 (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (e_vld_ff),
      .num      (e_num_ff),
      .den      (e_den_ff),
      .side_in  ({e_c_ff, e_gt_ff, e_tir_ff, e_den0_ff}),
      .out_vld  (dv1_vld),
      .quo      (q_sin2),
      .side_out (dv1_side)
   );

   sfr_div #(.NW(46), .DW(17), .QW(QW), .SW(1)) u_div_ratio (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (e_vld_ff),
      .num      ({e_d_ff, 30'b0}),
      .den      (e_s_ff),
      .side_in  (e_s_ff == '0),
      .out_vld  (dv2_vld),
      .quo      (q_ratio),
      .side_out (dv2_side)
   );

   // stage F: clamp quotients, form the root argument
   logic [W-1:0] sin2, qq;
   logic         f_vld_ff, f_gt_ff, f_tir_ff;
   logic [60:0]  f_v_ff;
   logic [W-1:0] f_qq_ff, f_c_ff;

   always_comb begin
      if (dv1_side[0]) begin
         sin2 = '0;
      end else begin
         sin2 = (q_sin2 > ONE) ? ONE : q_sin2;
      end
      if (dv2_side) begin
         qq = '0;
      end else begin
         qq = (q_ratio > ONE) ? ONE : q_ratio;
      end
   end

   always_ff @(posedge clock) begin
      f_v_ff   <= 61'(ONE - sin2) << 30;
      f_qq_ff  <= qq;
      f_c_ff   <= dv1_side[W+2:3];
      f_gt_ff  <= dv1_side[2];
      f_tir_ff <= dv1_side[1];
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= dv1_vld && dv2_vld;
      end
   end

   // refraction cosine
   logic          sq_vld;
   logic [QW-1:0] sq_root;
   logic [2*W+1:0] sq_side;

   sfr_sqrt #(.VW(61), .RW(QW), .SW(2 * W + 2)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (f_vld_ff),
      .val      (f_v_ff),
      .side_in  ({f_c_ff, f_qq_ff, f_gt_ff, f_tir_ff}),
      .out_vld  (sq_vld),
      .root     (sq_root),
      .side_out (sq_side)
   );

   // stage G: pick cosine, r0 = qq^2
   logic [W-1:0] cn, g_qq;
   logic [61:0]  r0_full;
   logic         g_vld_ff, g_tir_ff;
   logic [W-1:0] g_t_ff, g_r0_ff;

   assign g_qq    = sq_side[W+1:2];
   assign r0_full = 62'(g_qq) * 62'(g_qq);

   always_comb begin
      if (sq_side[1]) begin
         cn = (sq_root > ONE) ? ONE : sq_root;
      end else begin
         cn = sq_side[2*W+1:W+2];
      end
   end

   always_ff @(posedge clock) begin
      g_t_ff   <= ONE - cn;
      g_r0_ff  <= r0_full[60:30];
      g_tir_ff <= sq_side[0];
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= sq_vld;
      end
   end

   // stages H..K: t^2, t^4, t^5, (1 - r0) * t^5
   logic [61:0]  h_p, i_p, j_p, k_p;
   logic         h_vld_ff, i_vld_ff, j_vld_ff, k_vld_ff;
   logic         h_tir_ff, i_tir_ff, j_tir_ff, k_tir_ff;
   logic [W-1:0] h_t2_ff, h_t_ff, h_r0_ff;
   logic [W-1:0] i_t4_ff, i_t_ff, i_r0_ff;
   logic [W-1:0] j_t5_ff, j_r0_ff;
   logic [W-1:0] k_m_ff, k_r0_ff;

   assign h_p = 62'(g_t_ff) * 62'(g_t_ff);
   assign i_p = 62'(h_t2_ff) * 62'(h_t2_ff);
   assign j_p = 62'(i_t4_ff) * 62'(i_t_ff);
   assign k_p = 62'(ONE - j_r0_ff) * 62'(j_t5_ff);

   always_ff @(posedge clock) begin
      h_t2_ff  <= h_p[60:30];
      h_t_ff   <= g_t_ff;
      h_r0_ff  <= g_r0_ff;
      h_tir_ff <= g_tir_ff;
      i_t4_ff  <= i_p[60:30];
      i_t_ff   <= h_t_ff;
      i_r0_ff  <= h_r0_ff;
      i_tir_ff <= h_tir_ff;
      j_t5_ff  <= j_p[60:30];
      j_r0_ff  <= i_r0_ff;
      j_tir_ff <= i_tir_ff;
      k_m_ff   <= k_p[60:30];
      k_r0_ff  <= j_r0_ff;
      k_tir_ff <= j_tir_ff;
      if (reset) begin
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= j_vld_ff;
      end
   end

   // stage L: sum, saturate, round to Q1.15
   logic [31:0]      r_sum, r_sat, r_rnd;
   sfr_pkg::rsp_type rsp_in, rsp_ff;
   logic             rsp_vld_ff;

   always_comb begin
      r_sum = 32'(k_r0_ff) + 32'(k_m_ff);
      r_sat = (r_sum > 32'(ONE)) ? 32'(ONE) : r_sum;
      r_rnd = (r_sat + 32'd16384) >> 15;
      if (k_tir_ff) begin
         rsp_in.reflectance    = 16'h8000;
         rsp_in.total_internal = 1'b1;
      end else begin
         rsp_in.reflectance    = (r_rnd > 32'd32768) ? 16'h8000 : r_rnd[15:0];
         rsp_in.total_internal = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= k_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ src/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// Schlick Fresnel port checker
// Watches the top-level ports for result range, timing and busy behavior.
// ----------------------------------------------------------------------------
module sfr_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sfr_pkg::rsp_type rsp_item
);

   a_never_busy: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy high outside reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.reflectance <= 16'h8000)
      else $error("reflectance above one");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.total_internal |-> rsp_item.reflectance == 16'h8000)
      else $error("total internal reflection without full reflectance");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, sfr_pkg::LATENCY))
      else $error("result without an item accepted at the pipeline depth");

endmodule

bind schlick_fresnel_reflectance sfr_checker u_sfr_checker (.*);

@@ dv/sfr_reflectance_checker.sv @@
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance checker
// Watches the request and response channels, computes the expected
// reflectance of every accepted surface hit and compares it in order.
// ----------------------------------------------------------------------------
module sfr_reflectance_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  sfr_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  sfr_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending_count,
   output int               hit_count,
   output int               tir_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned UNITY = 64'd1 << 30;

   sfr_pkg::rsp_type reflect_q[$];

   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic sfr_pkg::rsp_type fresnel_predict(sfr_pkg::req_type hit);
      sfr_pkg::rsp_type res;
      longint dot;
      longint unsigned n1, n2, cosv, om, num, den, sin2, diff, sum, quo;
      longint unsigned r0, t, t2, t4, t5, refl, q16;
      dot = longint'(hit.eye_x) * longint'(hit.normal_x)
          + longint'(hit.eye_y) * longint'(hit.normal_y)
          + longint'(hit.eye_z) * longint'(hit.normal_z);
      n1 = longint'(hit.index_from);
      n2 = longint'(hit.index_to);
      if (dot < 0) dot = 0;
      if (dot > (64'sd1 <<< 28)) dot = 64'sd1 <<< 28;
      cosv = longint'(dot) << 2;   // Q.28 to Q.30
      res.total_internal = 1'b0;
      if (n1 > n2) begin
         om = UNITY - q30_mul(cosv, cosv);
         num = n1 * n1 * om;
         den = n2 * n2;
         if (num > den * UNITY) begin
            res.reflectance = 16'd32768;
            res.total_internal = 1'b1;
            return res;
         end
         sin2 = (num == 0 || den == 0) ? 0 : num / den;
         if (sin2 > UNITY) sin2 = UNITY;
         cosv = int_sqrt((UNITY - sin2) << 30);
         if (cosv > UNITY) cosv = UNITY;
      end
      diff = (n1 > n2) ? n1 - n2 : n2 - n1;
      sum = n1 + n2;
      quo = (sum == 0) ? 0 : (diff << 30) / sum;
      if (quo > UNITY) quo = UNITY;
      r0 = q30_mul(quo, quo);
      t = UNITY - cosv;
      t2 = q30_mul(t, t);
      t4 = q30_mul(t2, t2);
      t5 = q30_mul(t4, t);
      refl = r0 + q30_mul(UNITY - r0, t5);
      if (refl > UNITY) refl = UNITY;
      q16 = (refl + (64'd1 << 14)) >> 15;
      if (q16 > 32768) q16 = 32768;
      res.reflectance = q16[15:0];
      return res;
   endfunction

   always @(posedge clock) begin
      sfr_pkg::rsp_type want;
      if (reset) begin
         fail_count = 0;
         hit_count = 0;
         tir_count = 0;
      end else begin
         if (start && !busy) reflect_q = {reflect_q, fresnel_predict(req_item)};
         if (rsp_valid) begin
            if (reflect_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                        rsp_item.reflectance, rsp_item.total_internal);
            end else begin
               want = reflect_q.pop_front();
               hit_count++;
               if (rsp_item.total_internal) tir_count++;
               if (rsp_item.reflectance !== want.reflectance) begin
                  fail_count++;
                  $display("%0t: reflectance expected %0d actual %0d", $time,
                           want.reflectance, rsp_item.reflectance);
               end
               if (rsp_item.total_internal !== want.total_internal) begin
                  fail_count++;
                  $display("%0t: total_internal expected %0b actual %0b", $time,
                           want.total_internal, rsp_item.total_internal);
               end
            end
         end
      end
      pending_count = reflect_q.size();
   end

endmodule

@@ dv/tb_schlick_fresnel_reflectance.sv @@
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance testbench
// Drives directed and random surface hits with random start gaps; a
// checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_schlick_fresnel_reflectance;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_HITS = 1030;
   localparam int CALM_TAIL = 150;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [15:0] UNIT = 16'sd16384;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sfr_pkg::req_type req_item = '0;
   logic             rsp_valid;
   sfr_pkg::rsp_type rsp_item;
   int               fail_count, pending_count, hit_count, tir_count;
   int               cycle_count = 0;
   int               sent_count = 0;

   always #5 clock = ~clock;

   schlick_fresnel_reflectance u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   sfr_reflectance_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count),
      .hit_count(hit_count), .tir_count(tir_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("schlick_fresnel_reflectance test failed");
         $finish;
      end
   end

   // present one hit, hold it until accepted, optionally idle afterward
   task automatic send_hit(sfr_pkg::req_type hit, bit may_idle);
      int gap;
      @(negedge clock);
      req_item = hit;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         start = 1'b0;
         req_item = '{default: 16'($urandom)};
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic sfr_pkg::req_type make_hit(logic signed [15:0] ex, logic signed [15:0] ey,
                                                 logic signed [15:0] ez, logic signed [15:0] nx,
                                                 logic signed [15:0] ny, logic signed [15:0] nz,
                                                 logic [15:0] n1, logic [15:0] n2);
      sfr_pkg::req_type hit;
      hit.eye_x = ex; hit.eye_y = ey; hit.eye_z = ez;
      hit.normal_x = nx; hit.normal_y = ny; hit.normal_z = nz;
      hit.index_from = n1; hit.index_to = n2;
      return hit;
   endfunction

   function automatic logic [15:0] rand_index();
      return 16'($urandom_range(16384, 65535));
   endfunction

   function automatic logic signed [15:0] rand_comp(bit full);
      if (full) return 16'($urandom);
      return 16'($signed($urandom_range(0, 18918)) - 9459);
   endfunction

   function automatic sfr_pkg::req_type random_hit();
      sfr_pkg::req_type hit;
      bit full;
      logic [15:0] n1;
      full = ($urandom_range(0, 3) == 0);
      hit.eye_x = rand_comp(full); hit.eye_y = rand_comp(full); hit.eye_z = rand_comp(full);
      hit.normal_x = rand_comp(full); hit.normal_y = rand_comp(full);
      hit.normal_z = rand_comp(full);
      n1 = rand_index();
      hit.index_from = n1;
      case ($urandom_range(0, 3))
         0: hit.index_to = n1;
         1: hit.index_to = (n1 > 16400) ? n1 - 16'($urandom_range(1, 16)) : n1;
         default: hit.index_to = rand_index();
      endcase
      return hit;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // head-on, air to glass and glass to air
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 16384, 24576), 1);
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 24576, 16384), 1);
      // grazing: zero cosine, total internal reflection when leaving denser medium
      send_hit(make_hit(UNIT, 0, 0, 0, UNIT, 0, 24576, 16384), 1);
      send_hit(make_hit(UNIT, 0, 0, 0, UNIT, 0, 16384, 24576), 1);
      // equal indices
      send_hit(make_hit(0, UNIT, 0, 0, UNIT, 0, 21845, 21845), 1);
      send_hit(make_hit(0, 0, UNIT, 0, 0, 11585, 65535, 65535), 1);
      // zero indices: entering zero head-on and grazing, both zero
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 16384, 0), 1);
      send_hit(make_hit(UNIT, 0, 0, 0, UNIT, 0, 16384, 0), 1);
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 0, 0), 1);
      // back-facing, dot clamps to zero
      send_hit(make_hit(UNIT, 0, 0, -UNIT, 0, 0, 16384, 65535), 1);
      send_hit(make_hit(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 16384), 1);
      // oversize vectors clamp to one
      send_hit(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 65535, 16384), 1);
      send_hit(make_hit(-32768, -32768, -32768, -32768, -32768, -32768, 16384, 65535), 1);
      // near the critical angle, 45 degrees with small index step
      send_hit(make_hit(11585, 11585, 0, UNIT, 0, 0, 23170, 16384), 1);
      send_hit(make_hit(11585, 11585, 0, UNIT, 0, 0, 23169, 16384), 1);
      send_hit(make_hit(11585, 11585, 0, UNIT, 0, 0, 23171, 16384), 1);
      send_hit(make_hit(11585, 11585, 0, 0, 0, UNIT, 16385, 16384), 1);
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 65535, 16384), 0);
      send_hit(make_hit(UNIT, 0, 0, UNIT, 0, 0, 16384, 65535), 0);
      send_hit(make_hit(9459, 9459, 9459, 9459, 9459, 9459, 32768, 16384), 0);
      send_hit(make_hit(-1, 1, -1, 1, -1, 1, 65535, 65534), 0);

      for (int i = 0; i < RANDOM_HITS; i++)
         send_hit(random_hit(), i < RANDOM_HITS - CALM_TAIL);

      @(negedge clock);
      start = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (sfr_pkg::LATENCY + 10) @(posedge clock);

      $display("sent %0d surface hits, checked %0d results, %0d total internal",
               sent_count, hit_count, tir_count);
      if (fail_count == 0) begin
         $display("schlick_fresnel_reflectance test passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("schlick_fresnel_reflectance test failed");
      end
      $finish;
   end

endmodule
